FILE: rtl/core/hng_pkg.sv
package hng_pkg;

  localparam int H_W     = 16;
  localparam int D_W     = H_W + 1;
  localparam int WREG_W  = 11;
  localparam int CREG_W  = 13;
  localparam int COMP_W  = 16;
  localparam int NY_W    = 15;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int Q_W     = 15;
  localparam int S_W     = 34;
  localparam int ACC_W   = 69;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int WIDTH_LIMIT = 1024;
  localparam int ROWS_LIMIT  = 4096;
  localparam int DIM_MIN     = 3;
  localparam int TWO_Q10     = 2048;

  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  typedef struct packed {
    logic                  neg_x;
    logic [H_W-1:0]        mag_x;
    logic                  neg_z;
    logic [H_W-1:0]        mag_z;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
  } hng_vec_t;

  typedef struct packed {
    logic [COMP_W-1:0]     normal_x;
    logic [NY_W-1:0]       normal_y;
    logic [COMP_W-1:0]     normal_z;
    logic [COL_W-1:0]      centre_col;
    logic [ROW_W-1:0]      centre_row;
  } hng_res_t;

endpackage

FILE: rtl/core/hng_if.sv
interface hng_height_if import hng_pkg::*; ;
  logic           valid;
  logic           ready;
  logic [H_W-1:0] height_y;
  modport source (output valid, height_y, input ready);
  modport sink (input valid, height_y, output ready);
endinterface

interface hng_normal_if import hng_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] normal_x;
  logic [NY_W-1:0]          normal_y;
  logic signed [COMP_W-1:0] normal_z;
  logic [COL_W-1:0]         centre_col;
  logic [ROW_W-1:0]         centre_row;
  modport source (output valid, normal_x, normal_y, normal_z, centre_col, centre_row,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, centre_col, centre_row,
                output ready);
endinterface

FILE: rtl/core/hng_cfg.sv
module hng_cfg import hng_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic [WREG_W-1:0] row_width,
  output logic [CREG_W-1:0] row_count
);

  localparam int WMAX = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
  localparam int RMAX = (MAX_ROWS < ROWS_LIMIT) ? MAX_ROWS : ROWS_LIMIT;

  logic [WREG_W-1:0] w_in, w_clamped;
  logic [CREG_W-1:0] c_in, c_clamped;
  logic              wr;

  assign wr   = psel && penable && pwrite;
  assign w_in = pwdata[WREG_W-1:0];
  assign c_in = pwdata[CREG_W-1:0];

  always_comb begin
    if (w_in < WREG_W'(DIM_MIN)) w_clamped = WREG_W'(DIM_MIN);
    else if (w_in > WREG_W'(WMAX)) w_clamped = WREG_W'(WMAX);
    else w_clamped = w_in;
    if (c_in < CREG_W'(DIM_MIN)) c_clamped = CREG_W'(DIM_MIN);
    else if (c_in > CREG_W'(RMAX)) c_clamped = CREG_W'(RMAX);
    else c_clamped = c_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= WREG_W'(WMAX);
      row_count <= CREG_W'(RMAX);
    end else if (wr) begin
      unique case (paddr[2])
        REG_ROW_WIDTH: row_width <= w_clamped;
        REG_ROW_COUNT: row_count <= c_clamped;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_ROW_WIDTH: prdata = DATA_W'(row_width);
        REG_ROW_COUNT: prdata = DATA_W'(row_count);
        default: prdata = '0;
      endcase
    end
  end

endmodule

FILE: rtl/core/hng_window.sv
module hng_window import hng_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WREG_W-1:0] row_width,
  input  logic [CREG_W-1:0] row_count,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [H_W-1:0]    height,
  output logic              vec_valid,
  input  logic              vec_ready,
  output hng_vec_t          vec
);

  localparam int WMAX = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
  localparam int RMAX = (MAX_ROWS < ROWS_LIMIT) ? MAX_ROWS : ROWS_LIMIT;
  localparam int CW   = $clog2(WMAX);
  localparam int RW   = $clog2(RMAX);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_WIN  = 4'b0100,
    S_HOLD = 4'b1000
  } win_state_t;

  win_state_t state;

  logic [H_W-1:0] mem_a [WMAX];
  logic [H_W-1:0] mem_b [WMAX];
  logic [H_W-1:0] rd_a, rd_b;
  logic [CW-1:0]  rd_addr_a;

  logic [CW-1:0]  col_cnt, c_eff, c_reg;
  logic [RW-1:0]  row_cnt, r_eff, r_reg;
  logic [H_W-1:0] h_reg, w0, w1, right;
  logic signed [D_W-1:0] dz, dx;
  logic           has_right, interior;

  always_comb begin
    c_eff = (WREG_W'(col_cnt) >= row_width) ? '0 : col_cnt;
    r_eff = (CREG_W'(row_cnt) >= row_count) ? '0 : row_cnt;
    rd_addr_a = (state == S_IDLE) ? c_eff : c_reg + CW'(1);
    right = has_right ? rd_a : '0;
    dx = $signed({1'b0, w0}) - $signed({1'b0, right});
    interior = (r_reg >= RW'(2)) && (c_reg != '0) && has_right;
  end

  assign item_ready = (state == S_IDLE);
  assign vec_valid  = (state == S_HOLD);

  always_ff @(posedge clk) begin
    rd_a <= mem_a[rd_addr_a];
    rd_b <= mem_b[c_eff];
    if (state == S_READ) begin
      mem_a[c_reg] <= h_reg;
      mem_b[c_reg] <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      col_cnt <= '0;
      row_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            h_reg     <= height;
            c_reg     <= c_eff;
            r_reg     <= r_eff;
            has_right <= (WREG_W'(c_eff) + WREG_W'(1)) < row_width;
            state     <= S_READ;
          end
        end
        S_READ: begin
          w0    <= w1;
          w1    <= rd_a;
          dz    <= $signed({1'b0, rd_b}) - $signed({1'b0, h_reg});
          state <= S_WIN;
        end
        S_WIN: begin
          if (has_right) begin
            col_cnt <= c_reg + CW'(1);
          end else begin
            col_cnt <= '0;
            if ((CREG_W'(r_reg) + CREG_W'(1)) >= row_count) row_cnt <= '0;
            else row_cnt <= r_reg + RW'(1);
          end
          vec.neg_x <= dx[D_W-1];
          vec.mag_x <= dx[D_W-1] ? H_W'(-dx) : H_W'(dx);
          vec.neg_z <= dz[D_W-1];
          vec.mag_z <= dz[D_W-1] ? H_W'(-dz) : H_W'(dz);
          vec.col   <= COL_W'(c_reg);
          vec.row   <= ROW_W'(r_reg - RW'(1));
          state     <= interior ? S_HOLD : S_IDLE;
        end
        S_HOLD: begin
          if (vec_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/hng_lane.sv
module hng_lane import hng_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [H_W-1:0] mag,
  input  logic [S_W-1:0] s,
  output logic           busy,
  output logic [Q_W-1:0] q
);

  localparam int TOP_BIT = Q_W - 1;
  localparam int BIT_W   = $clog2(Q_W);
  localparam int SQ_W    = 2 * H_W;

  logic signed [ACC_W-1:0] x, ys, ss, t, trial, s_ext, ys_sum;
  logic [SQ_W-1:0]         mag_sq;
  logic [BIT_W-1:0]        bit_idx;
  logic                    phase, take;

  assign s_ext  = $signed(ACC_W'(s));
  assign mag_sq = SQ_W'(mag) * SQ_W'(mag);
  assign take   = (trial <= t);
  assign ys_sum = take ? ys + (ss <<< 1) : ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (start) begin
      x       <= s_ext;
      ys      <= -(s_ext <<< (TOP_BIT + 2));
      ss      <= s_ext <<< (2 * TOP_BIT + 2);
      t       <= $signed(ACC_W'(mag_sq)) <<< (2 * Q_W);
      q       <= '0;
      bit_idx <= BIT_W'(TOP_BIT);
      phase   <= 1'b0;
      busy    <= 1'b1;
    end else if (busy) begin
      if (!phase) begin
        trial <= x + ys + ss;
        phase <= 1'b1;
      end else begin
        if (take) begin
          x          <= trial;
          q[bit_idx] <= 1'b1;
        end
        ys    <= ys_sum >>> 1;
        ss    <= ss >>> 2;
        phase <= 1'b0;
        if (bit_idx == '0) busy <= 1'b0;
        else bit_idx <= bit_idx - BIT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/hng_norm.sv
module hng_norm import hng_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     vec_valid,
  output logic     vec_ready,
  input  hng_vec_t vec,
  output logic     res_valid,
  input  logic     res_ready,
  output hng_res_t res
);

  localparam int SQ_W = 2 * H_W;

  typedef enum logic [4:0] {
    N_IDLE  = 5'b00001,
    N_SQ    = 5'b00010,
    N_START = 5'b00100,
    N_RUN   = 5'b01000,
    N_OUT   = 5'b10000
  } norm_state_t;

  norm_state_t state;
  hng_vec_t    v;
  logic [S_W-1:0]    s_reg;
  logic [SQ_W-1:0]   sq_x, sq_z;
  logic [Q_W-1:0]    qx, qy, qz;
  logic [2:0]        busy;
  logic [COMP_W-1:0] qx16, qz16;
  logic              start;

  assign sq_x  = SQ_W'(v.mag_x) * SQ_W'(v.mag_x);
  assign sq_z  = SQ_W'(v.mag_z) * SQ_W'(v.mag_z);
  assign start = (state == N_START);

  assign vec_ready = (state == N_IDLE);
  assign res_valid = (state == N_OUT);

  assign qx16 = COMP_W'(qx);
  assign qz16 = COMP_W'(qz);
  assign res.normal_x   = v.neg_x ? COMP_W'(0) - qx16 : qx16;
  assign res.normal_y   = NY_W'(qy);
  assign res.normal_z   = v.neg_z ? COMP_W'(0) - qz16 : qz16;
  assign res.centre_col = v.col;
  assign res.centre_row = v.row;

  hng_lane u_lane_x (.clk, .rst, .start, .mag(v.mag_x), .s(s_reg), .busy(busy[0]), .q(qx));
  hng_lane u_lane_y (.clk, .rst, .start, .mag(H_W'(TWO_Q10)), .s(s_reg), .busy(busy[1]),
                     .q(qy));
  hng_lane u_lane_z (.clk, .rst, .start, .mag(v.mag_z), .s(s_reg), .busy(busy[2]), .q(qz));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (vec_valid) begin
            v     <= vec;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          s_reg <= S_W'(sq_x) + S_W'(sq_z) + S_W'(TWO_Q10 * TWO_Q10);
          state <= N_START;
        end
        N_START: state <= N_RUN;
        N_RUN: begin
          if (busy == '0) state <= N_OUT;
        end
        N_OUT: begin
          if (res_ready) state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/heightmap_normal_generator.sv
// height map normal generator: heights enter in row-major order, one item per handshake; for
// each interior vertex a unit normal in signed Q1.14 leaves with its column and row, once the
// height below it has arrived. a height item passes the row buffers in order: one read of
// both row memories, a write-back plus a second read of the row above, then the window
// update. an item that yields a normal also passes the normalizer: three root-search lanes
// resolve 15 result bits, each bit in a trial step and a decide step, and the row buffers keep
// taking items meanwhile until the next normal needs the normalizer. results wait in an
// output register. row_width and row_count are written over the apb port (addresses 0 and 4)
// and clamped to 3..1024 and 3..4096. no clearing pass after reset.
module heightmap_normal_generator import hng_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic              clk,
  input  logic              rst,
  hng_height_if.sink        height_in,
  hng_normal_if.source      normal_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [WREG_W-1:0] row_width;
  logic [CREG_W-1:0] row_count;
  logic              vec_valid, vec_ready, res_valid, res_ready, out_valid;
  hng_vec_t          vec;
  hng_res_t          res, out_reg;

  assign pready = 1'b1;

  hng_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_ROWS(MAX_ROWS)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .row_width, .row_count
  );

  hng_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_ROWS(MAX_ROWS)) u_window (
    .clk, .rst, .row_width, .row_count,
    .item_valid(height_in.valid), .item_ready(height_in.ready), .height(height_in.height_y),
    .vec_valid, .vec_ready, .vec
  );

  hng_norm u_norm (
    .clk, .rst, .vec_valid, .vec_ready, .vec, .res_valid, .res_ready, .res
  );

  assign res_ready = !out_valid || normal_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      if (res_valid) out_reg <= res;
    end
  end

  assign normal_out.valid      = out_valid;
  assign normal_out.normal_x   = $signed(out_reg.normal_x);
  assign normal_out.normal_y   = out_reg.normal_y;
  assign normal_out.normal_z   = $signed(out_reg.normal_z);
  assign normal_out.centre_col = out_reg.centre_col;
  assign normal_out.centre_row = out_reg.centre_row;

endmodule

FILE: rtl/core/hng_chk.sv
module hng_chk import hng_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [COMP_W-1:0] normal_x,
  input logic [NY_W-1:0]          normal_y,
  input logic signed [COMP_W-1:0] normal_z,
  input logic [COL_W-1:0]         centre_col,
  input logic [ROW_W-1:0]         centre_row
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
      && $stable(normal_z) && $stable(centre_col) && $stable(centre_row))
    else $error("item dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item shown after reset");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_y >= NY_W'(256) && normal_y <= NY_W'(16384))
    else $error("normal y out of range");

  a_xz_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
      && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
    else $error("normal x or z out of range");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> centre_col != '0 && centre_row != '0)
    else $error("normal for a border vertex");

endmodule

bind heightmap_normal_generator hng_chk u_hng_chk (
  .clk(clk),
  .rst(rst),
  .out_valid(normal_out.valid),
  .out_ready(normal_out.ready),
  .normal_x(normal_out.normal_x),
  .normal_y(normal_out.normal_y),
  .normal_z(normal_out.normal_z),
  .centre_col(normal_out.centre_col),
  .centre_row(normal_out.centre_row)
);
